FILE: rtl/acc_tilt_pkg.sv
// Shared types, constants and the arctangent table for the tilt angle pipeline.
// No dependencies; every other file of the block imports this package.
package acc_tilt_pkg;

    // Width of one accelerometer axis sample.
    localparam int SAMPLE_W = 16;

    // Bit-serial square root: one result bit per cell over a 64-bit radicand.
    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = 32;
    localparam int MAG_W      = 32;

    // CORDIC datapath widths. Roll operands are samples scaled by 2^24, pitch
    // operands are Q16 values; both leave headroom for the CORDIC gain.
    localparam int ROLL_W  = 43;
    localparam int PITCH_W = 36;
    localparam int ANG_W   = 32;

    // Angle unit is 1/65536 centidegree.
    localparam logic signed [ANG_W-1:0] DEG90_UNITS = 32'sd589824000;
    localparam int ANGLE_TABLE_LEN = 24;

    // Output ranges and widths.
    localparam int ROLL_LIMIT  = 18000;
    localparam int PITCH_LIMIT = 9000;
    localparam int ROLL_OUT_W  = 16;
    localparam int PITCH_OUT_W = 15;

    // Axis samples that travel beside the square root cells.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } side_t;

    // atan(2^-i) in 1/65536 centidegree, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_units(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = 32'sd294912000;
            1:       val = 32'sd174096719;
            2:       val = 32'sd91987925;
            3:       val = 32'sd46694507;
            4:       val = 32'sd23437865;
            5:       val = 32'sd11730358;
            6:       val = 32'sd5866610;
            7:       val = 32'sd2933484;
            8:       val = 32'sd1466764;
            9:       val = 32'sd733385;
            10:      val = 32'sd366693;
            11:      val = 32'sd183346;
            12:      val = 32'sd91673;
            13:      val = 32'sd45837;
            14:      val = 32'sd22918;
            15:      val = 32'sd11459;
            16:      val = 32'sd5730;
            17:      val = 32'sd2865;
            18:      val = 32'sd1432;
            19:      val = 32'sd716;
            20:      val = 32'sd358;
            21:      val = 32'sd179;
            22:      val = 32'sd90;
            23:      val = 32'sd45;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/acc_tilt_sqrt_cell.sv
// One cell of the bit-serial integer square root chain: settles one result bit.
// Depends on acc_tilt_pkg for widths and the sideband sample type.
module acc_tilt_sqrt_cell
    import acc_tilt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQRT_W-1:0] rem_in,
    input  logic [SQRT_W-1:0] res_in,
    input  side_t             side_in,
    output logic [SQRT_W-1:0] rem_out,
    output logic [SQRT_W-1:0] res_out,
    output side_t             side_out
);

    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * IDX);

    logic [SQRT_W-1:0] trial;
    logic [SQRT_W-1:0] rem_next;
    logic [SQRT_W-1:0] res_next;
    logic [SQRT_W-1:0] rem_reg;
    logic [SQRT_W-1:0] res_reg;
    side_t             side_reg;

    // Subtract the trial value when it fits and set this result bit.
    always_comb
    begin
        trial = res_in + BIT;
        if (rem_in >= trial)
        begin
            rem_next = rem_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    // Payload registers advance with the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule

FILE: rtl/acc_tilt_cordic_cell.sv
// One CORDIC vectoring cell: a shift-and-add rotation by atan(2^-IDX).
// Depends on acc_tilt_pkg for the angle width and the arctangent table.
module acc_tilt_cordic_cell
    import acc_tilt_pkg::*;
#(
    parameter int W   = 43,
    parameter int IDX = 0
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [W-1:0]     num_in,
    input  logic signed [W-1:0]     den_in,
    input  logic signed [ANG_W-1:0] ang_in,
    input  logic                    zero_in,
    output logic signed [W-1:0]     num_out,
    output logic signed [W-1:0]     den_out,
    output logic signed [ANG_W-1:0] ang_out,
    output logic                    zero_out
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_units(IDX);

    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;
    logic signed [W-1:0]     num_next;
    logic signed [W-1:0]     den_next;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [W-1:0]     num_reg;
    logic signed [W-1:0]     den_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic                    zero_reg;

    // Rotate toward the positive axis; a zero residue rotates clockwise.
    always_comb
    begin
        dx = num_in >>> IDX;
        dy = den_in >>> IDX;
        if (!num_in[W-1])
        begin
            den_next = den_in + dx;
            num_next = num_in - dy;
            ang_next = ang_in + ATAN;
        end
        else
        begin
            den_next = den_in - dx;
            num_next = num_in + dy;
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            ang_reg  <= ang_next;
            zero_reg <= zero_in;
        end
    end

    assign num_out  = num_reg;
    assign den_out  = den_reg;
    assign ang_out  = ang_reg;
    assign zero_out = zero_reg;

endmodule

FILE: rtl/acc_tilt_cordic.sv
// Pipelined atan2: half-plane pre-rotation, a chain of CORDIC cells, rounding
// and clamping. Depends on acc_tilt_pkg and acc_tilt_cordic_cell.
module acc_tilt_cordic
    import acc_tilt_pkg::*;
#(
    parameter int W     = 43,
    parameter int STEPS = 16,
    parameter int LIMIT = 18000,
    parameter int OUT_W = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [W-1:0]     num,
    input  logic signed [W-1:0]     den,
    output logic signed [OUT_W-1:0] angle
);

    localparam int MAG_BITS = ANG_W - 15;

    logic signed [W-1:0]     num_s  [0:STEPS];
    logic signed [W-1:0]     den_s  [0:STEPS];
    logic signed [ANG_W-1:0] ang_s  [0:STEPS];
    logic                    zero_s [0:STEPS];

    logic signed [W-1:0]     pre_num_next;
    logic signed [W-1:0]     pre_den_next;
    logic signed [ANG_W-1:0] pre_ang_next;
    logic signed [W-1:0]     pre_num_reg;
    logic signed [W-1:0]     pre_den_reg;
    logic signed [ANG_W-1:0] pre_ang_reg;
    logic                    pre_zero_reg;

    logic signed [ANG_W-1:0] ang_fin;
    logic [ANG_W-1:0]        ang_abs;
    logic [ANG_W:0]          ang_rnd;
    logic [MAG_BITS-1:0]     mag;
    logic [MAG_BITS-1:0]     mag_clamped;
    logic signed [OUT_W-1:0] angle_next;
    logic signed [OUT_W-1:0] angle_reg;

    // Move a vector in the left half-plane by plus or minus 90 degrees.
    always_comb
    begin
        pre_num_next = num;
        pre_den_next = den;
        pre_ang_next = '0;
        if (den[W-1])
        begin
            if (!num[W-1])
            begin
                pre_num_next = -den;
                pre_den_next = num;
                pre_ang_next = DEG90_UNITS;
            end
            else
            begin
                pre_num_next = den;
                pre_den_next = -num;
                pre_ang_next = -DEG90_UNITS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_num_reg  <= pre_num_next;
            pre_den_reg  <= pre_den_next;
            pre_ang_reg  <= pre_ang_next;
            pre_zero_reg <= (num == '0) && (den == '0);
        end
    end

    assign num_s[0]  = pre_num_reg;
    assign den_s[0]  = pre_den_reg;
    assign ang_s[0]  = pre_ang_reg;
    assign zero_s[0] = pre_zero_reg;

    // The rotation chain, one cell per iteration.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        acc_tilt_cordic_cell #(
            .W   (W),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .num_in   (num_s[i]),
            .den_in   (den_s[i]),
            .ang_in   (ang_s[i]),
            .zero_in  (zero_s[i]),
            .num_out  (num_s[i+1]),
            .den_out  (den_s[i+1]),
            .ang_out  (ang_s[i+1]),
            .zero_out (zero_s[i+1])
        );
    end

    // Round to whole centidegrees, half away from zero, then clamp.
    always_comb
    begin
        ang_fin     = ang_s[STEPS];
        ang_abs     = ang_fin[ANG_W-1] ? ANG_W'(-ang_fin) : ANG_W'(ang_fin);
        ang_rnd     = {1'b0, ang_abs} + (ANG_W+1)'(32768);
        mag         = ang_rnd[ANG_W:16];
        mag_clamped = (mag > MAG_BITS'(LIMIT)) ? MAG_BITS'(LIMIT) : mag;
        if (zero_s[STEPS])
        begin
            angle_next = '0;
        end
        else if (ang_fin[ANG_W-1])
        begin
            angle_next = OUT_W'(-$signed({1'b0, mag_clamped}));
        end
        else
        begin
            angle_next = OUT_W'(mag_clamped);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

FILE: rtl/accel_tilt_angles.sv
// Tilt angles from one accelerometer sample: roll = atan2(y, z) and
// pitch = atan2(-x, sqrt(y*y + z*z)), both in hundredths of a degree, rounded.
// The block accepts one item per clock cycle while in_ready is high. Each
// item passes through CORDIC_STEPS + 37 register stages: three for the input
// register, squaring and summing, 32 for the bit-serial square root chain, and
// CORDIC_STEPS + 2 for the pre-rotation, CORDIC chain and rounding stage.
// Roll and pitch run through two CORDIC chains side by side. When the result
// is not taken, the whole pipeline holds and in_ready falls.
// Depends on acc_tilt_pkg, acc_tilt_sqrt_cell, acc_tilt_cordic_cell and
// acc_tilt_cordic.
module accel_tilt_angles
    import acc_tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_W-1:0]    acc_x,
    input  logic signed [SAMPLE_W-1:0]    acc_y,
    input  logic signed [SAMPLE_W-1:0]    acc_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [PITCH_OUT_W-1:0] pitch_cdeg,
    output logic signed [ROLL_OUT_W-1:0]  roll_cdeg
);

    localparam int LAT = CORDIC_STEPS + SQRT_STEPS + 5;

    logic              en;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;

    side_t             in_reg;
    side_t             sq_side_reg;
    logic [31:0]       yy_reg;
    logic [31:0]       zz_reg;
    side_t             sum_side_reg;
    logic [31:0]       sum_reg;

    logic [SQRT_W-1:0] rem_s  [0:SQRT_STEPS];
    logic [SQRT_W-1:0] res_s  [0:SQRT_STEPS];
    side_t             side_s [0:SQRT_STEPS];

    side_t                    last_side;
    logic [MAG_W-1:0]         mag;
    logic signed [ROLL_W-1:0]  roll_num;
    logic signed [ROLL_W-1:0]  roll_den;
    logic signed [PITCH_W-1:0] pitch_num;
    logic signed [PITCH_W-1:0] pitch_den;

    // The pipeline advances unless a finished result waits at the output.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // One valid bit per pipeline stage.
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LAT-1];

    // Input register, squares of y and z, then their sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg.x     <= acc_x;
            in_reg.y     <= acc_y;
            in_reg.z     <= acc_z;
            yy_reg       <= 32'(in_reg.y * in_reg.y);
            zz_reg       <= 32'(in_reg.z * in_reg.z);
            sq_side_reg  <= in_reg;
            sum_reg      <= yy_reg + zz_reg;
            sum_side_reg <= sq_side_reg;
        end
    end

    // Square root of the sum in Q16: the radicand is the sum shifted by 32.
    assign rem_s[0]  = {sum_reg, 32'd0};
    assign res_s[0]  = '0;
    assign side_s[0] = sum_side_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        acc_tilt_sqrt_cell #(
            .IDX (k)
        ) u_sqrt (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_s[k]),
            .res_in   (res_s[k]),
            .side_in  (side_s[k]),
            .rem_out  (rem_s[k+1]),
            .res_out  (res_s[k+1]),
            .side_out (side_s[k+1])
        );
    end

    // CORDIC operands: roll from y and z scaled by 2^24, pitch from -x in Q16
    // and the magnitude.
    assign last_side = side_s[SQRT_STEPS];
    assign mag       = res_s[SQRT_STEPS][MAG_W-1:0];
    assign roll_num  = {{(ROLL_W-SAMPLE_W-24){last_side.y[SAMPLE_W-1]}}, last_side.y, 24'd0};
    assign roll_den  = {{(ROLL_W-SAMPLE_W-24){last_side.z[SAMPLE_W-1]}}, last_side.z, 24'd0};
    assign pitch_num = -$signed({{(PITCH_W-SAMPLE_W-16){last_side.x[SAMPLE_W-1]}},
                                 last_side.x, 16'd0});
    assign pitch_den = $signed({{(PITCH_W-MAG_W){1'b0}}, mag});

    acc_tilt_cordic #(
        .W     (ROLL_W),
        .STEPS (CORDIC_STEPS),
        .LIMIT (ROLL_LIMIT),
        .OUT_W (ROLL_OUT_W)
    ) u_roll (
        .clk   (clk),
        .en    (en),
        .num   (roll_num),
        .den   (roll_den),
        .angle (roll_cdeg)
    );

    acc_tilt_cordic #(
        .W     (PITCH_W),
        .STEPS (CORDIC_STEPS),
        .LIMIT (PITCH_LIMIT),
        .OUT_W (PITCH_OUT_W)
    ) u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (pitch_num),
        .den   (pitch_den),
        .angle (pitch_cdeg)
    );

endmodule

FILE: verif/accel_tilt_angles_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for accel_tilt_angles: drives accelerometer samples, predicts
// pitch and roll with an independent CORDIC model, and checks every result in order.
// Depends on acc_tilt_pkg and the accel_tilt_angles RTL.
module accel_tilt_angles_test
    import acc_tilt_pkg::*;
();

    localparam int STEPS        = 16;
    localparam int LATENCY      = STEPS + 37;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_INDEX  = 500;
    localparam int MAX_PRINTS   = 40;

    // One input item as queued for the driver.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        bit                         drain_first;
    } accel_sample_t;

    // One expected pair of tilt angles.
    typedef struct packed {
        logic signed [PITCH_OUT_W-1:0] pitch;
        logic signed [ROLL_OUT_W-1:0]  roll;
    } tilt_pair_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_W-1:0]    acc_x = '0;
    logic signed [SAMPLE_W-1:0]    acc_y = '0;
    logic signed [SAMPLE_W-1:0]    acc_z = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [PITCH_OUT_W-1:0] pitch_cdeg;
    logic signed [ROLL_OUT_W-1:0]  roll_cdeg;

    accel_sample_t sample_queue[$];
    tilt_pair_t    expected_tilts[$];

    // atan(2^-i) in 1/65536 centidegree.
    longint atan_step [ANGLE_TABLE_LEN] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned in_flight = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned recv_hold = 0;
    int unsigned recv_count = 0;
    bit          hold_started = 1'b0;
    int unsigned drv_cycle = 0;
    int unsigned rcv_cycle = 0;
    int unsigned idle_cycles = 0;

    accel_tilt_angles #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pitch_cdeg(pitch_cdeg),
        .roll_cdeg (roll_cdeg)
    );

    always #2 clk = ~clk;

    // Integer square root, one result bit per iteration.
    function automatic longint unsigned root_floor(input longint unsigned radicand);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned probe;
        rem   = radicand;
        res   = 0;
        probe = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + probe)
            begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // CORDIC vectoring arctangent in centidegrees, rounded and clamped.
    function automatic longint vector_angle(input longint num_in, input longint den_in,
                                            input longint lim);
        longint num;
        longint den;
        longint acc;
        longint dx;
        longint dy;
        longint q;
        longint tmp;
        int     steps;
        num = num_in;
        den = den_in;
        acc = 0;
        if (num == 0 && den == 0)
            return 0;
        // Left half-plane: pre-rotate by a quarter turn toward the vector.
        if (den < 0)
        begin
            if (num >= 0)
            begin
                tmp = num;
                num = -den;
                den = tmp;
                acc = longint'(DEG90_UNITS);
            end
            else
            begin
                tmp = -num;
                num = den;
                den = tmp;
                acc = -longint'(DEG90_UNITS);
            end
        end
        steps = (STEPS < ANGLE_TABLE_LEN) ? STEPS : ANGLE_TABLE_LEN;
        for (int i = 0; i < steps; i++)
        begin
            dx = num >>> i;
            dy = den >>> i;
            // A zero residue counts as non-negative.
            if (num >= 0)
            begin
                den = den + dx;
                num = num - dy;
                acc = acc + atan_step[i];
            end
            else
            begin
                den = den - dx;
                num = num + dy;
                acc = acc - atan_step[i];
            end
        end
        // Round half away from zero to whole centidegrees.
        if (acc >= 0)
            q = (acc + 32768) >>> 16;
        else
            q = -((-acc + 32768) >>> 16);
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    // Expected pitch and roll for one sample.
    function automatic tilt_pair_t predict_tilt(input logic signed [SAMPLE_W-1:0] x,
                                                input logic signed [SAMPLE_W-1:0] y,
                                                input logic signed [SAMPLE_W-1:0] z);
        longint          xv;
        longint          yv;
        longint          zv;
        longint unsigned sumsq;
        longint          mag;
        longint          pitch;
        longint          roll;
        tilt_pair_t      res;
        xv    = x;
        yv    = y;
        zv    = z;
        sumsq = longint'(yv * yv + zv * zv);
        mag   = longint'(root_floor(sumsq << 32));
        roll  = vector_angle(yv * 16777216, zv * 16777216, ROLL_LIMIT);
        pitch = vector_angle(-xv * 65536, mag, PITCH_LIMIT);
        res.pitch = pitch[PITCH_OUT_W-1:0];
        res.roll  = roll[ROLL_OUT_W-1:0];
        return res;
    endfunction

    // Gap length: mostly none or short, now and then long; none at all in calm stretches.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] flip(input logic signed [SAMPLE_W-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic add_sample(input int x, input int y, input int z, input bit drain);
        accel_sample_t s;
        s.x           = x[SAMPLE_W-1:0];
        s.y           = y[SAMPLE_W-1:0];
        s.z           = z[SAMPLE_W-1:0];
        s.drain_first = drain;
        sample_queue.push_back(s);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Driver: offers queued items with random gaps, holding each until it is accepted.
    always @(posedge clk)
    begin : drive_proc
        int unsigned   flight_next;
        accel_sample_t next_item;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_gap  <= 0;
            in_flight <= 0;
        end
        else
        begin
            drv_cycle   <= drv_cycle + 1;
            flight_next = in_flight;
            if (in_valid && in_ready)
            begin
                flight_next  = flight_next + 1;
                samples_sent <= samples_sent + 1;
            end
            if (out_valid && out_ready)
                flight_next = flight_next - 1;
            in_flight <= flight_next;
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0 &&
                         !(sample_queue[0].drain_first && flight_next != 0))
                begin
                    next_item = sample_queue.pop_front();
                    acc_x     <= next_item.x;
                    acc_y     <= next_item.y;
                    acc_z     <= next_item.z;
                    in_valid  <= 1'b1;
                    send_gap  <= pick_gap(((drv_cycle / 1200) % 4) == 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold so that the pipeline fills.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            rcv_cycle <= rcv_cycle + 1;
            if (out_valid && out_ready)
                recv_count <= recv_count + 1;
            if (!hold_started && recv_count >= HOLD_AFTER)
            begin
                hold_started <= 1'b1;
                recv_hold    <= HOLD_CYCLES;
                out_ready    <= 1'b0;
            end
            else if (recv_hold != 0)
            begin
                recv_hold <= recv_hold - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= pick_gap(((rcv_cycle / 1500) % 3) == 2);
            end
        end
    end

    // Monitor: checks each delivered result against the oldest prediction,
    // then records the prediction for any item accepted at this edge.
    always @(posedge clk)
    begin : check_proc
        tilt_pair_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tilts.size() == 0)
                begin
                    report_mismatch($sformatf("result pitch %0d roll %0d with none expected",
                                              pitch_cdeg, roll_cdeg));
                end
                else
                begin
                    want = expected_tilts.pop_front();
                    if (pitch_cdeg !== want.pitch)
                        report_mismatch($sformatf("pitch %0d, expected %0d",
                                                  pitch_cdeg, want.pitch));
                    if (roll_cdeg !== want.roll)
                        report_mismatch($sformatf("roll %0d, expected %0d",
                                                  roll_cdeg, want.roll));
                end
                results_checked <= results_checked + 1;
            end
            if (in_valid && in_ready)
                expected_tilts.push_back(predict_tilt(acc_x, acc_y, acc_z));
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles with no item accepted", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stim_proc
        int          kind;
        int          ax;
        int          ay;
        int          az;
        int unsigned mask;

        // Both operands zero, axis-aligned vectors, left half-plane and extremes.
        add_sample(0, 0, 0, 1'b0);
        add_sample(0, 0, 1, 1'b0);
        add_sample(0, 0, -1, 1'b0);
        add_sample(0, 1, 0, 1'b0);
        add_sample(0, -1, 0, 1'b0);
        add_sample(0, 1, -1, 1'b0);
        add_sample(0, -1, -1, 1'b0);
        add_sample(5, 0, 0, 1'b0);
        add_sample(-5, 0, 0, 1'b0);
        add_sample(-32768, 0, 0, 1'b0);
        add_sample(32767, 0, 0, 1'b0);
        add_sample(-32768, -32768, -32768, 1'b0);
        add_sample(32767, 32767, 32767, 1'b0);
        add_sample(0, -32768, -32768, 1'b0);
        add_sample(0, 32767, -32768, 1'b0);
        add_sample(0, -32768, 32767, 1'b0);
        add_sample(32767, -32768, -32768, 1'b0);
        add_sample(-32768, 32767, 32767, 1'b0);
        add_sample(1, 1, 1, 1'b0);
        add_sample(-1, -1, -1, 1'b0);
        add_sample(0, 5, 0, 1'b0);
        add_sample(0, 0, -32768, 1'b0);
        add_sample(-32768, 0, -32768, 1'b0);
        add_sample(300, -200, 16384, 1'b0);

        // Random samples of several shapes.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                ax = $signed(16'($urandom()));
                ay = $signed(16'($urandom()));
                az = $signed(16'($urandom()));
            end
            else if (kind < 55)
            begin
                ax = $urandom_range(0, 128) - 64;
                ay = $urandom_range(0, 128) - 64;
                az = $urandom_range(0, 128) - 64;
            end
            else if (kind < 70)
            begin
                // Near rest: one axis carries about 1 g, the others small noise.
                ax = $urandom_range(0, 1200) - 600;
                ay = $urandom_range(0, 1200) - 600;
                az = flip(16'($urandom_range(15000, 17500)));
                case ($urandom_range(0, 2))
                    0:
                    begin
                        mask = ax;
                        ax   = az;
                        az   = mask;
                    end
                    1:
                    begin
                        mask = ay;
                        ay   = az;
                        az   = mask;
                    end
                    default: ;
                endcase
            end
            else if (kind < 80)
            begin
                mask = $urandom_range(1, 7);
                ax = mask[0] ? 0 : $signed(16'($urandom()));
                ay = mask[1] ? 0 : $signed(16'($urandom()));
                az = mask[2] ? 0 : $signed(16'($urandom()));
            end
            else if (kind < 90)
            begin
                ax = $urandom_range(0, 32767);
                ay = $signed(flip(16'(ax)));
                az = $signed(flip(16'(ax)));
                ax = $signed(flip(16'(ax)));
            end
            else
            begin
                ax = pick_extreme();
                ay = pick_extreme();
                az = pick_extreme();
            end
            add_sample(ax, ay, az, n == DRAIN_INDEX);
        end

        // Reset held low, then released.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every sample is accepted and every result has come back.
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || in_flight != 0);
        repeat (2 * LATENCY) @(negedge clk);

        if (expected_tilts.size() != 0)
            report_mismatch($sformatf("%0d results never delivered", expected_tilts.size()));

        $display("Sent %0d samples (directed extremes and random shapes), checked %0d results,",
                 samples_sent, results_checked);
        $display("with random stalls, one %0d-cycle output hold and one full drain pause.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
